/* rtl/wvhg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wvhg_pkg
// Shared widths, register indexes, reset values and stage types for the
// windowed variance height gate.
// ----------------------------------------------------------------------------
package wvhg_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int THRESH_W   = 24;
    localparam int MARGIN_W   = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_VAR_THRESHOLD = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_JUMP_MARGIN   = 8'd1;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 24'd10000;
    localparam logic [MARGIN_W-1:0] MARGIN_RESET = 16'd100;

    // word handed from the window/sums pipe to the gate stage
    typedef struct packed {
        logic                valid;   // a word is present
        logic                res;     // window full: this word gives a result
        logic [SAMPLE_W-1:0] z;       // newest sample
    } t_gate_in;

endpackage

/* rtl/wvhg_window.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wvhg_window
// Sample window with running sum and running sum of squares. Two stages:
// squares and sum at accept, then sum of squares and the two wide products.
// ----------------------------------------------------------------------------
module wvhg_window
    import wvhg_pkg::*;
#(
    parameter int WINDOW_LEN = 5,
    localparam int SUM_W   = SAMPLE_W + $clog2(WINDOW_LEN),
    localparam int SQ_W    = 2 * SAMPLE_W,
    localparam int SUMSQ_W = SQ_W + $clog2(WINDOW_LEN),
    localparam int PROD_W  = 2 * SUM_W
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [SAMPLE_W-1:0] i_sample,
    output logic                o_ready,
    input  logic                i_advance,
    output t_gate_in            o_stage,
    output logic [PROD_W-1:0]   o_lhs_a,
    output logic [PROD_W-1:0]   o_lhs_b
);

    localparam int CNT_W = $clog2(WINDOW_LEN + 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(WINDOW_LEN);

    logic [SAMPLE_W-1:0] r_win [WINDOW_LEN];
    logic [CNT_W-1:0]    r_fill;
    logic [CNT_W-1:0]    n_fill;
    logic [SUM_W-1:0]    r_sum;
    logic [SUM_W-1:0]    n_sum;
    logic [SUMSQ_W-1:0]  r_sumsq;
    logic [SUMSQ_W-1:0]  n_sumsq;

    logic                r1_valid;
    logic                r1_res;
    logic [SAMPLE_W-1:0] r1_z;
    logic [SQ_W-1:0]     r1_sq_new;
    logic [SQ_W-1:0]     r1_sq_old;
    logic [SUM_W-1:0]    r1_sum;

    logic                r2_valid;
    logic                r2_res;
    logic [SAMPLE_W-1:0] r2_z;
    logic [PROD_W-1:0]   r2_lhs_a;
    logic [PROD_W-1:0]   r2_lhs_b;

    logic en1;
    logic en2;
    logic accept;

    assign en2    = !r2_valid || i_advance;
    assign en1    = !r1_valid || en2;
    assign accept = i_valid && en1;
    assign o_ready = en1;

    assign n_fill  = (r_fill < FULL) ? r_fill + CNT_W'(1) : r_fill;
    // oldest sample leaves, newest enters; zeros while filling
    assign n_sum   = r_sum + SUM_W'(i_sample) - SUM_W'(r_win[0]);
    assign n_sumsq = r_sumsq + SUMSQ_W'(r1_sq_new) - SUMSQ_W'(r1_sq_old);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WINDOW_LEN; i++) begin
                r_win[i] <= '0;
            end
            r_fill   <= '0;
            r_sum    <= '0;
            r1_valid <= 1'b0;
            r1_res   <= 1'b0;
        end else begin
            if (en1) begin
                r1_valid <= accept;
            end
            if (accept) begin
                for (int i = 0; i < WINDOW_LEN - 1; i++) begin
                    r_win[i] <= r_win[i+1];
                end
                r_win[WINDOW_LEN-1] <= i_sample;
                r_fill <= n_fill;
                r_sum  <= n_sum;
                r1_res <= (n_fill == FULL);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r1_z      <= i_sample;
            r1_sq_new <= SQ_W'(i_sample) * SQ_W'(i_sample);
            r1_sq_old <= SQ_W'(r_win[0]) * SQ_W'(r_win[0]);
            r1_sum    <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sumsq  <= '0;
            r2_valid <= 1'b0;
            r2_res   <= 1'b0;
        end else if (en2) begin
            r2_valid <= r1_valid;
            r2_res   <= r1_res;
            if (r1_valid) begin
                r_sumsq <= n_sumsq;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2 && r1_valid) begin
            r2_z     <= r1_z;
            r2_lhs_a <= PROD_W'(n_sumsq) * PROD_W'(WINDOW_LEN);
            r2_lhs_b <= PROD_W'(r1_sum) * PROD_W'(r1_sum);
        end
    end

    assign o_stage.valid = r2_valid;
    assign o_stage.res   = r2_res;
    assign o_stage.z     = r2_z;
    assign o_lhs_a       = r2_lhs_a;
    assign o_lhs_b       = r2_lhs_b;

endmodule

/* rtl/wvhg_gate.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wvhg_gate
// Variance compare, jump test against the last stable height, held output.
// Holds the result register towards the output channel.
// ----------------------------------------------------------------------------
module wvhg_gate
    import wvhg_pkg::*;
#(
    parameter int WINDOW_LEN = 5,
    localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW_LEN),
    localparam int PROD_W = 2 * SUM_W
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_gate_in            i_stage,
    input  logic [PROD_W-1:0]   i_lhs_a,
    input  logic [PROD_W-1:0]   i_lhs_b,
    input  logic [PROD_W-1:0]   i_rhs,
    input  logic [MARGIN_W-1:0] i_margin,
    output logic                o_advance,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [SAMPLE_W-1:0] o_height,
    output logic                o_stable,
    output logic                o_accepted
);

    logic                r_valid;
    logic [SAMPLE_W-1:0] r_held;
    logic [SAMPLE_W-1:0] r_last_stable;
    logic                r_stable;
    logic                r_accepted;

    logic                en3;
    logic                take;
    logic [PROD_W-1:0]   lhs;
    logic                stable;
    logic [SAMPLE_W-1:0] gap;
    logic                accepted;

    assign en3  = !r_valid || !i_stall;
    assign take = en3 && i_stage.valid && i_stage.res;

    // N*sum(x^2) >= (sum x)^2, no wrap
    assign lhs    = i_lhs_a - i_lhs_b;
    assign stable = lhs < i_rhs;
    assign gap    = (i_stage.z >= r_last_stable) ? i_stage.z - r_last_stable
                                                 : r_last_stable - i_stage.z;
    assign accepted = stable || (MARGIN_W'(gap) < i_margin);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid       <= 1'b0;
            r_held        <= '0;
            r_last_stable <= '0;
        end else begin
            if (en3) begin
                r_valid <= i_stage.valid && i_stage.res;
            end
            if (take) begin
                if (stable) begin
                    r_last_stable <= i_stage.z;
                end
                if (accepted) begin
                    r_held <= i_stage.z;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_stable   <= stable;
            r_accepted <= accepted;
        end
    end

    assign o_advance  = en3;
    assign o_valid    = r_valid;
    assign o_height   = r_held;
    assign o_stable   = r_stable;
    assign o_accepted = r_accepted;

endmodule

/* rtl/windowed_variance_height_gate_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_variance_height_gate_top
// Sliding-window variance gate for height samples.
//
//   channel  direction  handshake                     payload
//   in       in         i_in_valid / o_in_stall       i_sample_mm
//   out      out        o_out_valid / i_out_stall     o_height_mm, o_window_stable,
//                                                     o_sample_accepted
//   cfg      in         i_cfg_valid / o_cfg_ready     i_cfg_index, i_cfg_data
//
// One word accepted per cycle while o_in_stall is low; a result word passes the
// square stage, the product stage and the gate register before it is presented.
// The first WINDOW_LEN-1 samples after reset only fill the window, no result.
// Latency is set by the square stage, the product stage and the gate register.
// Reset is synchronous, active low; margin applies in the cycle after its write,
// threshold passes r_thresh and then the registered product r_rhs.
// A stalled output freezes the gate register; earlier stages keep filling bubbles.
// ----------------------------------------------------------------------------
module windowed_variance_height_gate_top
    import wvhg_pkg::*;
#(
    parameter int WINDOW_LEN = 5
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [SAMPLE_W-1:0]   i_sample_mm,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [SAMPLE_W-1:0]   o_height_mm,
    output logic                  o_window_stable,
    output logic                  o_sample_accepted,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW_LEN);
    localparam int PROD_W = 2 * SUM_W;

    logic [THRESH_W-1:0] r_thresh;
    logic [MARGIN_W-1:0] r_margin;
    logic [PROD_W-1:0]   r_rhs;

    logic                ready;
    logic                advance;
    t_gate_in            stage;
    logic [PROD_W-1:0]   lhs_a;
    logic [PROD_W-1:0]   lhs_b;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= THRESH_RESET;
            r_margin <= MARGIN_RESET;
            r_rhs    <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_VAR_THRESHOLD: r_thresh <= i_cfg_data[THRESH_W-1:0];
                    CFG_JUMP_MARGIN:   r_margin <= i_cfg_data[MARGIN_W-1:0];
                    default: ;
                endcase
            end
            // N*(N-1)*threshold, refreshed every cycle
            r_rhs <= PROD_W'(r_thresh) * PROD_W'(WINDOW_LEN * (WINDOW_LEN - 1));
        end
    end

    wvhg_window #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .i_sample  (i_sample_mm),
        .o_ready   (ready),
        .i_advance (advance),
        .o_stage   (stage),
        .o_lhs_a   (lhs_a),
        .o_lhs_b   (lhs_b)
    );

    wvhg_gate #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_gate (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_stage    (stage),
        .i_lhs_a    (lhs_a),
        .i_lhs_b    (lhs_b),
        .i_rhs      (r_rhs),
        .i_margin   (r_margin),
        .o_advance  (advance),
        .o_valid    (o_out_valid),
        .i_stall    (i_out_stall),
        .o_height   (o_height_mm),
        .o_stable   (o_window_stable),
        .o_accepted (o_sample_accepted)
    );

    assign o_in_stall = !ready;

endmodule
